[rtl/scp_pkg.sv]
package scp_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned InsetBits        = 15;
  localparam int unsigned MagFracBits      = 16;
  localparam int unsigned FracBits         = 24;

endpackage

[rtl/scp_sqrt_pipe.sv]
module scp_sqrt_pipe #(
  parameter int unsigned RadBits  = 36,
  parameter int unsigned SideBits = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [RadBits-1:0]       rad,
  input  logic [SideBits-1:0]      side_in,
  output logic                     out_valid,
  output logic [RadBits/2-1:0]     root,
  output logic [SideBits-1:0]      side_out
);

  localparam int unsigned Steps    = RadBits / 2;
  localparam int unsigned RemBits  = Steps + 2;

  logic [Steps:1]                 vld;
  logic [RadBits-1:0]             rad_q  [1:Steps];
  logic [RemBits-1:0]             rem_q  [1:Steps];
  logic [Steps-1:0]               root_q [1:Steps];
  logic [SideBits-1:0]            side_q [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic                v_c;
    logic [RadBits-1:0]  rad_c;
    logic [RemBits-1:0]  rem_c;
    logic [Steps-1:0]    root_c;
    logic [SideBits-1:0] side_c;
    logic [RemBits-1:0]  rem_sh;
    logic [RemBits-1:0]  trial;
    logic                take;
    if (s == 0) begin : g_head
      assign v_c    = in_valid;
      assign rad_c  = rad;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = side_in;
    end else begin : g_tail
      assign v_c    = vld[s];
      assign rad_c  = rad_q[s];
      assign rem_c  = rem_q[s];
      assign root_c = root_q[s];
      assign side_c = side_q[s];
    end
    always_comb begin
      rem_sh = {rem_c[RemBits-3:0], rad_c[RadBits-1 -: 2]};
      trial  = {root_c, 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= v_c;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_q[s+1]  <= {rad_c[RadBits-3:0], 2'b00};
        rem_q[s+1]  <= take ? rem_sh - trial : rem_sh;
        root_q[s+1] <= {root_c[Steps-2:0], take};
        side_q[s+1] <= side_c;
      end
    end
  end

  assign out_valid = vld[Steps];
  assign root      = root_q[Steps];
  assign side_out  = side_q[Steps];

endmodule

[rtl/scp_div_pipe.sv]
module scp_div_pipe #(
  parameter int unsigned NumBits  = 40,
  parameter int unsigned DenBits  = 20,
  parameter int unsigned SideBits = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [NumBits-1:0]    num,
  input  logic [DenBits-1:0]    den,
  input  logic [SideBits-1:0]   side_in,
  output logic                  out_valid,
  output logic [NumBits-1:0]    quot,
  output logic [SideBits-1:0]   side_out
);

  logic [NumBits:1]     vld;
  logic [NumBits-1:0]   num_q  [1:NumBits];
  logic [DenBits:0]     rem_q  [1:NumBits];
  logic [DenBits-1:0]   den_q  [1:NumBits];
  logic [SideBits-1:0]  side_q [1:NumBits];

  for (genvar s = 0; s < NumBits; s++) begin : g_step
    logic                v_c;
    logic [NumBits-1:0]  num_c;
    logic [DenBits:0]    rem_c;
    logic [DenBits-1:0]  den_c;
    logic [SideBits-1:0] side_c;
    logic [DenBits:0]    rem_sh;
    logic                take;
    if (s == 0) begin : g_head
      assign v_c    = in_valid;
      assign num_c  = num;
      assign rem_c  = '0;
      assign den_c  = den;
      assign side_c = side_in;
    end else begin : g_tail
      assign v_c    = vld[s];
      assign num_c  = num_q[s];
      assign rem_c  = rem_q[s];
      assign den_c  = den_q[s];
      assign side_c = side_q[s];
    end
    always_comb begin
      rem_sh = {rem_c[DenBits-1:0], num_c[NumBits-1]};
      take   = rem_sh >= {1'b0, den_c};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= v_c;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        num_q[s+1]  <= {num_c[NumBits-2:0], take};
        rem_q[s+1]  <= take ? rem_sh - {1'b0, den_c} : rem_sh;
        den_q[s+1]  <= den_c;
        side_q[s+1] <= side_c;
      end
    end
  end

  assign out_valid = vld[NumBits];
  assign quot      = num_q[NumBits];
  assign side_out  = side_q[NumBits];

endmodule

[rtl/segment_closest_point_core.sv]
// channel | dir | tdata fields (low bit up)                       | tuser
// s_axis  | in  | a_x, a_y, b_x, b_y, q_x, q_y, inset, zero pad     | -
// m_axis  | out | near_x, near_y                                    | -
// One item enters per cycle unless the output stalls. Most of the pipeline depth
// comes from the restoring square root (one root bit per stage) and two restoring
// dividers (one quotient bit per stage).
// The whole pipe advances when the output stage is empty or being taken; a stall
// freezes every stage. Reset clears all valid bits; payload registers are not reset.
module segment_closest_point_core #(
  parameter int unsigned COORD_BITS = scp_pkg::CoordBitsDefault
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_x, a_y, b_x, b_y, q_x, q_y, inset
  input  logic [((6*COORD_BITS+scp_pkg::InsetBits+7)/8)*8-1:0] s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // near_x, near_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata
);
  import scp_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned DB   = CB + 1;           // difference width
  localparam int unsigned L2B  = 2 * DB;           // len2 width (unsigned)
  localparam int unsigned MB   = L2B / 2 + MagFracBits; // mag width (Q16)
  localparam int unsigned DOTB = 2 * DB + 1;       // |dot| width
  localparam int unsigned PNB  = DOTB + 32;        // proj numerator width
  localparam int unsigned PB   = MB + 1;           // clamped proj width
  localparam int unsigned FNB  = PB + FracBits;    // frac numerator width
  localparam int unsigned OWB  = ((2*CB+7)/8)*8;
  localparam int unsigned IB   = InsetBits;

  localparam logic [1:0] FselZero = 2'd0;
  localparam logic [1:0] FselOne  = 2'd1;
  localparam logic [1:0] FselDiv  = 2'd2;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
    logic                 short_seg;
    logic [IB-1:0]        inset;
    logic                 dneg;
    logic [DOTB-1:0]      adot;
  } s1_t;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
    logic                 short_seg;
    logic [IB-1:0]        inset;
    logic                 dneg;
    logic [MB-1:0]        mag;
  } s2_t;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
    logic                 short_seg;
    logic [1:0]           fsel;
  } s4_t;

  logic adv;
  logic out_v;
  assign adv           = !out_v || m_axis_tready;
  assign s_axis_tready = adv;

  // ---- stage 1: differences
  logic signed [CB-1:0] i_ax, i_ay, i_bx, i_by, i_qx, i_qy;
  logic [IB-1:0]        i_in;
  assign i_ax = s_axis_tdata[0*CB +: CB];
  assign i_ay = s_axis_tdata[1*CB +: CB];
  assign i_bx = s_axis_tdata[2*CB +: CB];
  assign i_by = s_axis_tdata[3*CB +: CB];
  assign i_qx = s_axis_tdata[4*CB +: CB];
  assign i_qy = s_axis_tdata[5*CB +: CB];
  assign i_in = s_axis_tdata[6*CB +: IB];

  logic signed [DB-1:0] e_dx, e_dy, e_px, e_py;
  assign e_dx = DB'(i_bx) - DB'(i_ax);
  assign e_dy = DB'(i_by) - DB'(i_ay);
  assign e_px = DB'(i_qx) - DB'(i_ax);
  assign e_py = DB'(i_qy) - DB'(i_ay);

  logic                  v1;
  logic signed [DB-1:0]  r_dx, r_dy, r_px, r_py;
  logic signed [CB-1:0]  r_ax, r_ay;
  logic [IB-1:0]         r_in;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r_dx <= e_dx; r_dy <= e_dy; r_px <= e_px; r_py <= e_py;
      r_ax <= i_ax; r_ay <= i_ay; r_in <= i_in;
    end
  end

  // stage 2: products
  logic signed [2*DB-1:0] p_xx, p_yy, p_xp, p_yp;
  logic                   v2;
  logic signed [DB-1:0]   r2_dx, r2_dy;
  logic signed [CB-1:0]   r2_ax, r2_ay;
  logic [IB-1:0]          r2_in;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xx <= r_dx * r_dx; p_yy <= r_dy * r_dy;
      p_xp <= r_dx * r_px; p_yp <= r_dy * r_py;
      r2_dx <= r_dx; r2_dy <= r_dy; r2_ax <= r_ax; r2_ay <= r_ay; r2_in <= r_in;
    end
  end

  // stage 3: sums
  logic [L2B-1:0]          len2;
  logic signed [DOTB-1:0]  dot;
  assign len2 = L2B'(unsigned'(p_xx)) + L2B'(unsigned'(p_yy));
  assign dot  = DOTB'(p_xp) + DOTB'(p_yp);

  s1_t                  s1;
  logic                 v3;
  logic [L2B-1:0]       r_len2;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r_len2       <= len2;
      s1.ax        <= r2_ax;
      s1.ay        <= r2_ay;
      s1.dx        <= r2_dx;
      s1.dy        <= r2_dy;
      s1.short_seg <= len2 <= L2B'(1);
      s1.inset     <= r2_in;
      s1.dneg      <= dot[DOTB-1];
      s1.adot      <= dot[DOTB-1] ? DOTB'(-dot) : DOTB'(dot);
    end
  end

  // ---- square root: mag = floor(sqrt(len2 << 32))
  logic [2*MB-1:0] rad;
  logic            v4;
  logic [MB-1:0]   mag;
  s1_t             s1o;
  assign rad = {r_len2, 32'd0};

  scp_sqrt_pipe #(.RadBits(2*MB), .SideBits($bits(s1_t))) u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v3), .rad(rad), .side_in(s1),
    .out_valid(v4), .root(mag), .side_out(s1o)
  );

  // ---- proj magnitude = (|dot| << 32) / mag
  s2_t           s2;
  logic [PNB-1:0] pnum;
  logic [MB-1:0]  pden;
  assign pnum = {s1o.adot, 32'd0};
  assign pden = (mag == '0) ? MB'(1) : mag;
  always_comb begin
    s2.ax = s1o.ax; s2.ay = s1o.ay; s2.dx = s1o.dx; s2.dy = s1o.dy;
    s2.short_seg = s1o.short_seg; s2.inset = s1o.inset; s2.dneg = s1o.dneg;
    s2.mag = mag;
  end

  logic           v5;
  logic [PNB-1:0] pmag;
  s2_t            s2o;
  scp_div_pipe #(.NumBits(PNB), .DenBits(MB), .SideBits($bits(s2_t))) u_pdiv (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v4), .num(pnum), .den(pden),
    .side_in(s2), .out_valid(v5), .quot(pmag), .side_out(s2o)
  );

  // ---- stage: inset and clamp. proj sign known; clamp magnitude to mag.
  logic [PB:0]  off, m_ext, pc, pofs, hi_lim, pfin;
  logic         psat;
  logic         pneg_z;
  assign off   = (PB+1)'(s2o.inset) << MagFracBits;
  assign m_ext = (PB+1)'(s2o.mag);
  assign psat  = (pmag > PNB'(s2o.mag));
  always_comb begin
    pneg_z = 1'b0;
    // clamp |proj| to mag (sign handled separately)
    pc     = psat ? m_ext : (PB+1)'(pmag);
    hi_lim = m_ext - off;
    pofs   = (s2o.dneg ? '0 : pc) + off;
    pfin   = pc;
    if (s2o.inset != '0) begin
      if ((off << 1) < m_ext) begin
        pfin = (pofs > hi_lim) ? hi_lim : pofs;
        if (pfin < off) pfin = off;
      end else begin
        pfin = m_ext >> 1;
      end
    end else begin
      pneg_z = s2o.dneg;
    end
  end

  s4_t          s4;
  logic         v6;
  logic [PB:0]  r_pfin;
  logic [MB-1:0] r_mag;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r_pfin <= pfin;
      r_mag  <= (s2o.mag == '0) ? MB'(1) : s2o.mag;
      s4.ax <= s2o.ax; s4.ay <= s2o.ay; s4.dx <= s2o.dx; s4.dy <= s2o.dy;
      s4.short_seg <= s2o.short_seg;
      if (pneg_z || pfin == '0)             s4.fsel <= FselZero;
      else if (pfin >= (PB+1)'(s2o.mag))    s4.fsel <= FselOne;
      else                                  s4.fsel <= FselDiv;
    end
  end

  // ---- frac = (proj << 24) / mag
  logic [FNB-1:0] fnum;
  assign fnum = {r_pfin[PB-1:0], 24'd0};
  logic           v7;
  logic [FNB-1:0] fq;
  s4_t            s4o;
  scp_div_pipe #(.NumBits(FNB), .DenBits(MB), .SideBits($bits(s4_t))) u_fdiv (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v6), .num(fnum), .den(r_mag),
    .side_in(s4), .out_valid(v7), .quot(fq), .side_out(s4o)
  );

  logic [FracBits:0] frac;
  always_comb begin
    case (s4o.fsel)
      FselZero: frac = '0;
      FselOne:  frac = (FracBits+1)'(1) << FracBits;
      default:  frac = (FracBits+1)'(fq);
    endcase
  end

  // ---- scale stage: |d| * frac
  logic [DB-1:0]           adx, ady;
  logic [DB+FracBits:0]    mx, my;
  logic                    v8;
  logic                    nx, ny, sh8;
  logic signed [CB-1:0]    ax8, ay8;
  assign adx = s4o.dx[DB-1] ? DB'(-s4o.dx) : DB'(s4o.dx);
  assign ady = s4o.dy[DB-1] ? DB'(-s4o.dy) : DB'(s4o.dy);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mx  <= (DB+FracBits+1)'(adx) * (DB+FracBits+1)'(frac);
      my  <= (DB+FracBits+1)'(ady) * (DB+FracBits+1)'(frac);
      nx  <= s4o.dx[DB-1]; ny <= s4o.dy[DB-1];
      sh8 <= s4o.short_seg; ax8 <= s4o.ax; ay8 <= s4o.ay;
    end
  end

  // ---- round and output register
  logic [DB:0] rxm, rym;
  logic [CB-1:0] ox, oy;
  assign rxm = (DB+1)'((mx + (DB+FracBits+1)'(1 << 23)) >> FracBits);
  assign rym = (DB+1)'((my + (DB+FracBits+1)'(1 << 23)) >> FracBits);
  assign ox  = sh8 ? ax8 : CB'(ax8 + (nx ? CB'(-rxm) : CB'(rxm)));
  assign oy  = sh8 ? ay8 : CB'(ay8 + (ny ? CB'(-rym) : CB'(rym)));

  logic [CB-1:0] o_x, o_y;
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= v8;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_x <= ox; o_y <= oy;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = OWB'({o_y, o_x});

endmodule

[rtl/scp_checker.sv]
module scp_checker #(
  parameter int unsigned COORD_BITS = scp_pkg::CoordBitsDefault
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata
);

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid right after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind segment_closest_point_core scp_checker #(.COORD_BITS(COORD_BITS)) u_scp_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

[tb/sv/scp_checker.sv]
`timescale 1ns / 100ps

module tb_scp_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    s_axis_tvalid,
  input  logic                                                    s_axis_tready,
  input  logic [((6*COORD_BITS+scp_pkg::InsetBits+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                                    m_axis_tvalid,
  input  logic                                                    m_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]                       m_axis_tdata,
  output int                                                      fail_count,
  output int                                                      pending,
  output int                                                      point_count
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  point_t nearest_q[$];

  // floor(sqrt(v)) on a wide radicand
  function automatic logic [127:0] isqrt_wide(logic [127:0] v);
    logic [127:0] root, bitv, trial;
    root = 0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      trial = root + bitv;
      if (v >= trial) begin
        v    = v - trial;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [63:0] scale_coord(logic signed [63:0] d,
                                                     logic [63:0] frac);
    logic [127:0] m, r;
    m = (d < 0) ? -d : d;
    r = (m * frac + (128'd1 << 23)) >> 24;
    return (d < 0) ? -$signed(r[63:0]) : $signed(r[63:0]);
  endfunction

  function automatic point_t nearest_point(logic [6*COORD_BITS+scp_pkg::InsetBits-1:0] w);
    logic signed [63:0] ax, ay, bx, by, qx, qy, dx, dy, px, py, dot, proj, m, off;
    logic [63:0] inset, frac;
    logic [127:0] len2, mag, adot, pm;
    point_t res;
    ax = $signed(w[0*COORD_BITS +: COORD_BITS]);
    ay = $signed(w[1*COORD_BITS +: COORD_BITS]);
    bx = $signed(w[2*COORD_BITS +: COORD_BITS]);
    by = $signed(w[3*COORD_BITS +: COORD_BITS]);
    qx = $signed(w[4*COORD_BITS +: COORD_BITS]);
    qy = $signed(w[5*COORD_BITS +: COORD_BITS]);
    inset = w[6*COORD_BITS +: scp_pkg::InsetBits];
    dx = bx - ax; dy = by - ay; px = qx - ax; py = qy - ay;
    len2 = dx * dx + dy * dy;
    res.x = ax[COORD_BITS-1:0];
    res.y = ay[COORD_BITS-1:0];
    if (len2 > 1) begin
      mag  = isqrt_wide(len2 << 32);
      m    = mag[63:0];
      dot  = dx * px + dy * py;
      adot = (dot < 0) ? -dot : dot;
      pm   = (adot << 32) / mag;
      proj = (dot < 0) ? -$signed(pm[63:0]) : $signed(pm[63:0]);
      if (inset > 0) begin
        off = inset << 16;
        if (2 * off < m) begin
          if (proj > m) proj = m;
          if (proj < 0) proj = 0;
          proj = proj + off;
          if (proj > m - off) proj = m - off;
          if (proj < off) proj = off;
        end else begin
          proj = m >>> 1;
        end
      end
      if (proj <= 0) frac = 0;
      else if (proj >= m) frac = 64'd1 << 24;
      else frac = ((128'(proj) << 24) / mag);
      res.x = COORD_BITS'(ax + scale_coord(dx, frac));
      res.y = COORD_BITS'(ay + scale_coord(dy, frac));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    point_t want, got;
    int     errs;
    errs = 0;
    if (rst) begin
      fail_count  <= 0;
      point_count <= 0;
      pending     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        nearest_q.push_back(nearest_point(s_axis_tdata[6*COORD_BITS+scp_pkg::InsetBits-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[0 +: COORD_BITS];
        got.y = m_axis_tdata[COORD_BITS +: COORD_BITS];
        point_count <= point_count + 1;
        if (nearest_q.size() == 0) begin
          $error("unexpected transaction: near_x %0d near_y %0d", got.x, got.y);
          errs++;
        end else begin
          want = nearest_q.pop_front();
          if (want.x !== got.x) begin
            $error("near_x: expected %0d, actual %0d", want.x, got.x);
            errs++;
          end
          if (want.y !== got.y) begin
            $error("near_y: expected %0d, actual %0d", want.y, got.y);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= nearest_q.size();
    end
  end

endmodule

[tb/sv/tb_segment_closest_point_core.sv]
`timescale 1ns / 100ps

module tb_segment_closest_point_core;

  localparam int unsigned CB   = scp_pkg::CoordBitsDefault;
  localparam int unsigned IW   = ((6*CB+scp_pkg::InsetBits+7)/8)*8;
  localparam int unsigned OW   = ((2*CB+7)/8)*8;
  localparam int          LAT  = 4*CB + 100;
  localparam int          NRAND = 400;
  localparam longint      CYCLE_LIMIT = 200000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  int            fail_count, pending, point_count;
  longint        cycles = 0;
  bit            stim_done = 1'b0;
  int            n_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_closest_point_core #(.COORD_BITS(CB)) DUT (.*);

  tb_scp_checker #(.COORD_BITS(CB)) u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** segment_closest_point_core: FAILED **");
      $finish;
    end
  end

  // sink side: random stall before each transaction
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_segment(logic [CB-1:0] ax, ay, bx, by, qx, qy,
                              logic [scp_pkg::InsetBits-1:0] inset);
    int w;
    w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    s_axis_tdata  <= IW'({inset, qy, qx, by, bx, ay, ax});
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rnd_coord(int span);
    int mode;
    mode = $urandom_range(0, 3);
    if (mode == 0) return CB'($urandom);
    return CB'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  initial begin
    logic [CB-1:0] ax, ay, bx, by;
    logic [14:0] ins;
    int span;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // extremes, short segments, inset active and too large
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0);
    send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0);
    send_segment(16'd5, 16'd5, 16'd5, 16'd5, 16'd100, 16'hff00, 0);
    send_segment(16'd5, 16'd5, 16'd6, 16'd5, 16'd100, 16'd7, 3);
    send_segment(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 0);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd9, 10);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0, 16'hfff0, 16'd9, 10);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0, 16'd500, 16'd9, 10);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd9, 50);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd9, 15'h7fff);
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 15'h7fff);
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 15'h3fff);
    send_segment(16'd0, 16'd0, 16'd3, 16'hfffd, 16'd1, 16'd0, 0);
    send_segment(16'd10, 16'd10, 16'hfff6, 16'd20, 16'hffff, 16'h8000, 0);
    send_segment(16'hffff, 16'hffff, 16'h0000, 16'h7fff, 16'h7fff, 16'hffff, 1);
    for (int i = 0; i < NRAND; i++) begin
      span = ($urandom_range(0, 1) == 0) ? 40 : 32767;
      ax = rnd_coord(span); ay = rnd_coord(span);
      if ($urandom_range(0, 9) == 0) begin
        bx = ax + CB'($urandom_range(0, 2) - 1);
        by = ay + CB'($urandom_range(0, 2) - 1);
      end else begin
        bx = rnd_coord(span); by = rnd_coord(span);
      end
      case ($urandom_range(0, 3))
        0:       ins = 0;
        1:       ins = 15'($urandom);
        default: ins = 15'($urandom_range(0, span / 2));
      endcase
      send_segment(ax, ay, bx, by, rnd_coord(span), rnd_coord(span), ins);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    $display("Sent %0d segment queries with random gaps and stalls;", n_sent);
    $display("checked %0d nearest points, including short and inset cases.", point_count);
    if (fail_count == 0 && pending == 0)
      $display("** segment_closest_point_core: PASSED **");
    else
      $display("** segment_closest_point_core: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/scp_pkg.sv
rtl/scp_sqrt_pipe.sv
rtl/scp_div_pipe.sv
rtl/segment_closest_point_core.sv
rtl/scp_checker.sv
tb/sv/scp_checker.sv
tb/sv/tb_segment_closest_point_core.sv
